// ----- src/dtfb_pkg.sv -----
`default_nettype none

package dtfb_pkg;

    // Store geometry. The word for pixel (x, y) sits at y * MAX_WIDTH + x.
    // Both dimensions are powers of two, so the address is {y, x}.
    localparam int MAX_WIDTH   = 256;
    localparam int MAX_HEIGHT  = 256;
    localparam int X_W         = $clog2(MAX_WIDTH);
    localparam int Y_W         = $clog2(MAX_HEIGHT);
    localparam int ADDR_W      = X_W + Y_W;
    localparam int STORE_WORDS = MAX_WIDTH * MAX_HEIGHT;

    // Field widths.
    localparam int DATA_W  = 32;
    localparam int DIM_W   = 9;
    localparam int POS_W   = 16;
    localparam int FRAC_W  = 4;
    // Rounded pixel coordinate, signed: 12 integer bits plus one for rounding up.
    localparam int COORD_W = POS_W - FRAC_W + 1;

    // Configuration register indexes.
    localparam logic [1:0] CFG_FRAME_WIDTH  = 2'd0;
    localparam logic [1:0] CFG_FRAME_HEIGHT = 2'd1;
    localparam logic [1:0] CFG_CLEAR_COLOR  = 2'd2;
    localparam logic [1:0] CFG_CLEAR_DEPTH  = 2'd3;

    // Bits of the clear selection.
    localparam int CLR_COLOR_BIT = 0;
    localparam int CLR_DEPTH_BIT = 1;

    // Request kinds.
    typedef enum logic [1:0] {
        REQ_DRAW  = 2'd0,
        REQ_CLEAR = 2'd1,
        REQ_READ  = 2'd2
    } t_req;

    // Controller states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ACCESS,
        ST_CLEAR
    } t_state;

    // Write request to the pixel stores.
    typedef struct packed {
        logic [ADDR_W-1:0] addr;
        logic              color_we;
        logic              depth_we;
        logic [DATA_W-1:0] color;
        logic [DATA_W-1:0] depth;
    } t_store_wr;

    // Signed Q12.4 to a whole pixel, rounding half away from zero.
    function automatic logic signed [COORD_W-1:0] round_q12_4(
        input logic signed [POS_W-1:0] v
    );
        logic [POS_W:0]     mag;
        logic [POS_W:0]     sum;
        logic [COORD_W-1:0] q;
        mag = v[POS_W-1] ? ((POS_W+1)'(0) - {v[POS_W-1], v}) : {1'b0, v};
        sum = mag + (POS_W+1)'(1 << (FRAC_W - 1));
        q   = COORD_W'(sum >> FRAC_W);
        return v[POS_W-1] ? $signed(COORD_W'(0) - q) : $signed(q);
    endfunction

endpackage

`default_nettype wire

// ----- src/dtfb_store.sv -----
`default_nettype none

// Color and depth stores. One read port and one write port, read data
// registered in the cycle after the address.
module dtfb_store
    import dtfb_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rd_en,
    input  wire logic [ADDR_W-1:0] i_rd_addr,
    input  wire t_store_wr         i_wr,
    output logic      [DATA_W-1:0] o_rd_color,
    output logic      [DATA_W-1:0] o_rd_depth
);

    logic [DATA_W-1:0] r_color_mem [STORE_WORDS];
    logic [DATA_W-1:0] r_depth_mem [STORE_WORDS];
    logic [DATA_W-1:0] r_rd_color;
    logic [DATA_W-1:0] r_rd_depth;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_wr.color_we) begin
            r_color_mem[i_wr.addr] <= i_wr.color;
        end
        if (i_wr.depth_we) begin
            r_depth_mem[i_wr.addr] <= i_wr.depth;
        end
    end

    // Registered read port.
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_color <= r_color_mem[i_rd_addr];
            r_rd_depth <= r_depth_mem[i_rd_addr];
        end
    end

    assign o_rd_color = r_rd_color;
    assign o_rd_depth = r_rd_depth;

endmodule

`default_nettype wire

// ----- src/depth_tested_frame_buffer.sv -----
`default_nettype none

// Depth-tested frame buffer. A request is taken when start is high and busy is
// low; every request gives exactly one result, shown for one cycle with
// o_result_valid, and the receiver cannot stall it. A draw or a pixel read first
// reads the color and depth stores at the rounded position, then tests, writes
// back and registers the result. A clear writes one pixel per cycle over the
// configured frame; a clear with nothing selected or an empty frame, and an
// unused request kind, answer at once without a store access. Store contents
// are undefined until a pixel has been cleared or drawn.
module depth_tested_frame_buffer
    import dtfb_pkg::*;
(
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     start,
    output logic                          busy,
    input  wire logic [1:0]               i_req_type,
    input  wire logic signed [POS_W-1:0]  i_pos_x,
    input  wire logic signed [POS_W-1:0]  i_pos_y,
    input  wire logic signed [DATA_W-1:0] i_point_depth,
    input  wire logic [DATA_W-1:0]        i_point_color,
    input  wire logic                     i_depth_test,
    input  wire logic [1:0]               i_clear_select,
    input  wire logic                     i_cfg_we,
    input  wire logic [1:0]               i_cfg_index,
    input  wire logic [DATA_W-1:0]        i_cfg_data,
    output logic                          o_result_valid,
    output logic [DATA_W-1:0]             o_pixel_color,
    output logic                          o_pixel_written,
    output logic                          o_rejected
);

    // Configuration registers.
    logic [DIM_W-1:0]         r_frame_width;
    logic [DIM_W-1:0]         r_frame_height;
    logic [DATA_W-1:0]        r_clear_color;
    logic signed [DATA_W-1:0] r_clear_depth;

    // Control state.
    t_state           r_state, n_state;
    logic [X_W-1:0]   r_clr_x, n_clr_x;
    logic [Y_W-1:0]   r_clr_y, n_clr_y;
    logic             r_out_valid, n_out_valid;

    // Latched request.
    logic [1:0]               r_req_type;
    logic signed [DATA_W-1:0] r_depth;
    logic [DATA_W-1:0]        r_color;
    logic                     r_test;
    logic [1:0]               r_sel;
    logic                     r_in_range;
    logic [ADDR_W-1:0]        r_addr;

    // Result registers.
    logic [DATA_W-1:0] r_pixel_color, n_pixel_color;
    logic              r_pixel_written, n_pixel_written;
    logic              r_rejected, n_rejected;

    logic                      accept;
    logic [DIM_W-1:0]          eff_w;
    logic [DIM_W-1:0]          eff_h;
    logic signed [COORD_W-1:0] px;
    logic signed [COORD_W-1:0] py;
    logic                      in_range;
    logic [ADDR_W-1:0]         pix_addr;
    logic                      clear_needed;
    logic                      clr_x_last;
    logic                      clr_y_last;
    logic                      req_access;
    t_store_wr                 store_wr;
    logic [DATA_W-1:0]         rd_color;
    logic [DATA_W-1:0]         rd_depth;

    assign accept = start && !busy;
    assign busy   = (r_state != ST_IDLE);

    // Frame size clamped to the store size.
    assign eff_w = (r_frame_width > DIM_W'(MAX_WIDTH)) ? DIM_W'(MAX_WIDTH) : r_frame_width;
    assign eff_h = (r_frame_height > DIM_W'(MAX_HEIGHT)) ? DIM_W'(MAX_HEIGHT)
                                                         : r_frame_height;

    // Rounded pixel position and frame check of the incoming request.
    assign px = round_q12_4(i_pos_x);
    assign py = round_q12_4(i_pos_y);
    assign in_range = !px[COORD_W-1] && !py[COORD_W-1]
                   && (px[COORD_W-2:0] < (COORD_W-1)'(eff_w))
                   && (py[COORD_W-2:0] < (COORD_W-1)'(eff_h));
    assign pix_addr = {py[Y_W-1:0], px[X_W-1:0]};

    assign req_access   = (i_req_type == REQ_DRAW) || (i_req_type == REQ_READ);
    assign clear_needed = (i_clear_select != 2'b00) && (eff_w != '0) && (eff_h != '0);
    assign clr_x_last   = (DIM_W'(r_clr_x) == eff_w - DIM_W'(1));
    assign clr_y_last   = (DIM_W'(r_clr_y) == eff_h - DIM_W'(1));

    dtfb_store u_store (
        .i_clk      (i_clk),
        .i_rd_en    (accept),
        .i_rd_addr  (pix_addr),
        .i_wr       (store_wr),
        .o_rd_color (rd_color),
        .o_rd_depth (rd_depth)
    );

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    if (req_access) begin
                        n_state = ST_ACCESS;
                    end else if ((i_req_type == REQ_CLEAR) && clear_needed) begin
                        n_state = ST_CLEAR;
                    end
                end
            end
            ST_ACCESS: begin
                n_state = ST_IDLE;
            end
            ST_CLEAR: begin
                if (clr_x_last && clr_y_last) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Store writes, clear walk and results.
    always_comb begin
        n_out_valid       = 1'b0;
        n_pixel_color     = '0;
        n_pixel_written   = 1'b0;
        n_rejected        = 1'b0;
        n_clr_x           = r_clr_x;
        n_clr_y           = r_clr_y;
        store_wr          = '0;
        store_wr.addr     = r_addr;
        store_wr.color    = r_color;
        store_wr.depth    = r_depth;
        unique case (r_state)
            ST_IDLE: begin
                // Requests that change nothing answer at once.
                if (accept && !req_access
                    && !((i_req_type == REQ_CLEAR) && clear_needed)) begin
                    n_out_valid = 1'b1;
                end
            end
            ST_ACCESS: begin
                n_out_valid = 1'b1;
                if (!r_in_range) begin
                    n_rejected = 1'b1;
                end else if (r_req_type == REQ_DRAW) begin
                    if (!r_test) begin
                        store_wr.color_we = 1'b1;
                        n_pixel_written   = 1'b1;
                    end else if (r_depth >= $signed(rd_depth)) begin
                        store_wr.color_we = 1'b1;
                        store_wr.depth_we = 1'b1;
                        n_pixel_written   = 1'b1;
                    end
                end else begin
                    n_pixel_color = rd_color;
                end
            end
            ST_CLEAR: begin
                store_wr.addr     = {r_clr_y, r_clr_x};
                store_wr.color_we = r_sel[CLR_COLOR_BIT];
                store_wr.depth_we = r_sel[CLR_DEPTH_BIT];
                store_wr.color    = r_clear_color;
                store_wr.depth    = r_clear_depth;
                if (clr_x_last && clr_y_last) begin
                    n_out_valid = 1'b1;
                    n_clr_x     = '0;
                    n_clr_y     = '0;
                end else if (clr_x_last) begin
                    n_clr_x = '0;
                    n_clr_y = r_clr_y + Y_W'(1);
                end else begin
                    n_clr_x = r_clr_x + X_W'(1);
                end
            end
            default: begin
                n_out_valid = 1'b0;
            end
        endcase
    end

    // Control registers and configuration.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= ST_IDLE;
            r_clr_x        <= '0;
            r_clr_y        <= '0;
            r_out_valid    <= 1'b0;
            r_frame_width  <= DIM_W'(MAX_WIDTH);
            r_frame_height <= DIM_W'(MAX_HEIGHT);
            r_clear_color  <= '0;
            r_clear_depth  <= '0;
        end else begin
            r_state     <= n_state;
            r_clr_x     <= n_clr_x;
            r_clr_y     <= n_clr_y;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_FRAME_WIDTH:  r_frame_width  <= i_cfg_data[DIM_W-1:0];
                    CFG_FRAME_HEIGHT: r_frame_height <= i_cfg_data[DIM_W-1:0];
                    CFG_CLEAR_COLOR:  r_clear_color  <= i_cfg_data;
                    CFG_CLEAR_DEPTH:  r_clear_depth  <= $signed(i_cfg_data);
                    default:          r_clear_depth  <= r_clear_depth;
                endcase
            end
        end
    end

    // Request and result payload.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_req_type <= i_req_type;
            r_depth    <= i_point_depth;
            r_color    <= i_point_color;
            r_test     <= i_depth_test;
            r_sel      <= i_clear_select;
            r_in_range <= in_range;
            r_addr     <= pix_addr;
        end
        r_pixel_color   <= n_pixel_color;
        r_pixel_written <= n_pixel_written;
        r_rejected      <= n_rejected;
    end

    assign o_result_valid  = r_out_valid;
    assign o_pixel_color   = r_pixel_color;
    assign o_pixel_written = r_pixel_written;
    assign o_rejected      = r_rejected;

    // A result is only shown once the controller is free again.
    a_result_when_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> !busy)
        else $error("result shown while a transaction is still in progress");

    // A draw or read answers in the cycle after its store access.
    a_access_answers: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_ACCESS) |=> (o_result_valid && (r_state == ST_IDLE)))
        else $error("store access did not produce a result");

    // The clear walk position rests at zero outside a clear.
    a_walk_parked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_CLEAR) |-> ((r_clr_x == '0) && (r_clr_y == '0)))
        else $error("clear walk position not zero between clears");

    // Stores are written only during an access or a clear.
    a_no_idle_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE) |-> !(store_wr.color_we || store_wr.depth_we))
        else $error("store written while idle");

    // A rejected point never reports a write.
    a_reject_no_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> !(o_pixel_written && o_rejected))
        else $error("result both written and rejected");

endmodule

`default_nettype wire
